[src/lfps_pkg.sv]
`default_nettype none
package lfps_pkg;

  // Default widths of the sample and fraction fields.
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF   = 16;

  // Fixed field widths.
  localparam int SAMPLE_MAX_W = 16;
  localparam int GAIN_W       = 16;
  localparam int LIMIT_W      = 7;
  localparam int TICK_W       = 8;
  localparam int ACC_W        = 32;
  localparam int DRIVE_W      = 8;

  // Configuration port.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_MIN_COUNT      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_COUNT      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PREDICT_GAIN   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_STEER_LIMIT    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_LOSS_TIMEOUT   = 3'd7;

  // Datapath operations issued by the controller.
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
  localparam logic [OP_W-1:0] OP_NORM_DIV  = 5'd2;
  localparam logic [OP_W-1:0] OP_NORM_WB   = 5'd3;
  localparam logic [OP_W-1:0] OP_RATIO_DIV = 5'd4;
  localparam logic [OP_W-1:0] OP_RATIO_WB  = 5'd5;
  localparam logic [OP_W-1:0] OP_PMUL      = 5'd6;
  localparam logic [OP_W-1:0] OP_PMUL_WB   = 5'd7;
  localparam logic [OP_W-1:0] OP_EDIV      = 5'd8;
  localparam logic [OP_W-1:0] OP_EDIV_WB   = 5'd9;
  localparam logic [OP_W-1:0] OP_PROP_MUL  = 5'd10;
  localparam logic [OP_W-1:0] OP_PROP_WB   = 5'd11;
  localparam logic [OP_W-1:0] OP_INT_MUL   = 5'd12;
  localparam logic [OP_W-1:0] OP_INT_WB    = 5'd13;
  localparam logic [OP_W-1:0] OP_CLAMP     = 5'd14;
  localparam logic [OP_W-1:0] OP_COMMIT    = 5'd15;
  localparam logic [OP_W-1:0] OP_LOST      = 5'd16;
  localparam logic [OP_W-1:0] OP_DMUL      = 5'd17;
  localparam logic [OP_W-1:0] OP_DDIV      = 5'd18;
  localparam logic [OP_W-1:0] OP_DDIV_WB   = 5'd19;

  typedef struct packed {
    logic [SAMPLE_MAX_W-1:0] min_count;
    logic [SAMPLE_MAX_W-1:0] max_count;
    logic [GAIN_W-1:0]       prop_gain;
    logic [GAIN_W-1:0]       integ_gain;
    logic [GAIN_W-1:0]       predict_gain;
    logic [GAIN_W-1:0]       integral_limit;
    logic [LIMIT_W-1:0]      steer_limit;
    logic [TICK_W-1:0]       loss_timeout;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [1:0]      idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic line_seen;
    logic decay;
  } stat_t;

endpackage
`default_nettype wire

[src/lfps_div.sv]
`default_nettype none
// Unsigned restoring divider, one quotient bit per cycle. The dividend comes
// left-aligned; nbits_i says how many of its top bits take part.
module lfps_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 18,
  localparam int CNT_W = $clog2(NUM_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [CNT_W-1:0] nbits_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o
);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, num_r[NUM_W-1]};
    diff    = {1'b0, trial} - {2'b00, den_r};
    ge      = ~diff[DEN_W+1];
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= nbits_i;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num_i;
      den_r <= den_i;
      rem_r <= '0;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_r;
  assign quo_o  = quo_r;

endmodule
`default_nettype wire

[src/lfps_dpath.sv]
`default_nettype none
// Datapath: sample and state registers, one shared multiplier, the shared
// divider for the normalizations and the ratio, and reciprocal multipliers
// for the divisions by the constants 125 and 25.
module lfps_dpath import lfps_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  input  wire cfg_t                   cfg,
  input  wire logic                   clear_i,
  input  wire logic [SAMPLE_BITS-1:0] lc_amp_i,
  input  wire logic [SAMPLE_BITS-1:0] rc_amp_i,
  input  wire logic [SAMPLE_BITS-1:0] lp_amp_i,
  input  wire logic [SAMPLE_BITS-1:0] rp_amp_i,
  output stat_t                       stat,
  output logic [DRIVE_W-1:0]          drive_o,
  output logic                        valid_o
);

  localparam int S      = SAMPLE_BITS;
  localparam int F      = FRAC_BITS;
  localparam int N_W    = F + 1;
  localparam int SUM_W  = F + 2;
  localparam int R_W    = F + 2;
  localparam int E_W    = F + 11;
  localparam int MUL_B  = (F + 10 > ACC_W) ? F + 10 : ACC_W;
  localparam int PROD_W = GAIN_W + MUL_B;
  localparam int G_W    = PROD_W - 8;
  localparam int U_W    = MUL_B + 10;
  localparam int UC_W   = F + 9;
  localparam int I_W    = ACC_W + 2;
  localparam int DIV_NW = (2 * F + 1 > S + F) ? 2 * F + 1 : S + F;
  localparam int DIV_DW = (F + 2 > S) ? F + 2 : S;
  localparam int DCNT_W = $clog2(DIV_NW + 1);
  localparam int L_W    = F + LIMIT_W;
  localparam int LIM_W  = GAIN_W + F - 8;
  // Reciprocal of 125 for the error magnitude, exact over its whole range.
  localparam int QE_W   = E_W - 1;
  localparam int RQ_K   = QE_W + 7;
  localparam int RQ_MW  = QE_W + 1;
  localparam int RQ_PW  = QE_W + RQ_MW;
  // Reciprocal of 25 for the integral magnitude; decay is 23/25 of it.
  localparam int DK     = ACC_W + 5;
  localparam int DQ_W   = ACC_W - 4;
  localparam int DP_W   = 2 * ACC_W + 1;
  localparam longint ONE       = 64'sd1 <<< F;
  localparam longint VALID_MIN = (6 * ONE) / 100;
  localparam longint EPS       = ONE / 1000;
  localparam longint HALF      = ONE / 2;
  localparam longint INT32_MAX = 64'sh7FFF_FFFF;
  localparam longint RQ_M      = ((64'sd1 <<< RQ_K) + 124) / 125;
  localparam longint DM        = ((64'sd1 <<< DK) + 24) / 25;

  // State and working registers.
  logic [S-1:0]             amp_r [4];
  logic [N_W-1:0]           nv_r  [4];
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  last_r;
  logic [TICK_W-1:0]        loss_r;
  logic                     decay_r;
  logic signed [R_W-1:0]    ratio_r;
  logic signed [E_W-1:0]    e_r;
  logic signed [ACC_W-1:0]  inext_r;
  logic signed [U_W-1:0]    usum_r;
  logic signed [UC_W-1:0]   u_r;
  logic [PROD_W-1:0]        prod_r;
  logic [DRIVE_W-1:0]       drive_r;
  logic                     valid_r;
  logic [QE_W-1:0]          qe_r;
  logic [DQ_W-1:0]          qa_r;
  logic [4:0]               ra_r;
  logic [ACC_W-1:0]         q23_r;

  // Combinational values.
  logic [S-1:0]             amp_sel, minv, maxv, norm_d;
  logic [N_W-1:0]           norm_q, norm_v;
  logic [N_W+1:0]           three_half;
  logic [SUM_W-1:0]         sum_c;
  logic [N_W-1:0]           diff_c, sdiff_c;
  logic [E_W-2:0]           e_mag;
  logic [E_W-1:0]           e_neg;
  logic [ACC_W-1:0]         inext_mag, acc_mag;
  logic [G_W-1:0]           gterm;
  logic signed [E_W-1:0]    pt_s;
  logic signed [U_W-1:0]    gt_s;
  logic signed [I_W-1:0]    qe_s, isum, lim_s, inext_c;
  logic [I_W-1:0]           lim_u;
  logic [LIM_W-1:0]         lim_raw;
  logic [L_W-1:0]           l_u;
  logic signed [U_W-1:0]    l_us;
  logic signed [UC_W-1:0]   l_uc, eps_c, uc_c;
  logic signed [ACC_W-1:0]  l_32, lc_c;
  logic [UC_W-1:0]          u_mag, rnd;
  logic [ACC_W-1:0]         lc_mag;
  logic [DRIVE_W-1:0]       dmag_v, dmag_l;
  logic                     sat_hi, sat_lo, hold;
  logic [TICK_W-1:0]        loss_inc;
  logic [GAIN_W-1:0]        mul_a;
  logic [MUL_B-1:0]         mul_b;
  logic                     mul_en;
  logic                     div_start;
  logic [DIV_NW-1:0]        div_num, quo;
  logic [DCNT_W-1:0]        div_nbits;
  logic [DIV_DW-1:0]        div_den;
  logic                     div_done;
  logic [RQ_PW-1:0]         qe_prod;
  logic [DP_W-1:0]          qa_prod;
  logic [4:0]               ra_c, fr_c;
  logic [ACC_W-1:0]         dec_mag;

  lfps_div #(
    .NUM_W (DIV_NW),
    .DEN_W (DIV_DW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_i   (div_num),
    .nbits_i (div_nbits),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    minv    = cfg.min_count[S-1:0];
    maxv    = cfg.max_count[S-1:0];
    amp_sel = amp_r[cmd.idx];
    norm_d  = amp_sel - minv;
    norm_q  = quo[N_W-1:0];
    if (amp_sel <= minv) begin
      norm_v = '0;
    end else if (amp_sel >= maxv) begin
      norm_v = N_W'(ONE);
    end else begin
      norm_v = norm_q;
    end
    three_half = {2'b00, norm_v} + {1'b0, norm_v, 1'b0};

    sum_c   = SUM_W'(nv_r[0]) + SUM_W'(nv_r[1]);
    diff_c  = (nv_r[1] >= nv_r[0]) ? nv_r[1] - nv_r[0] : nv_r[0] - nv_r[1];
    sdiff_c = (nv_r[2] >= nv_r[3]) ? nv_r[2] - nv_r[3] : nv_r[3] - nv_r[2];

    e_neg     = -e_r;
    e_mag     = e_r[E_W-1] ? e_neg[E_W-2:0] : e_r[E_W-2:0];
    inext_mag = inext_r[ACC_W-1] ? ACC_W'(-inext_r) : ACC_W'(inext_r);
    acc_mag   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);

    gterm = prod_r[PROD_W-1:8];
    pt_s  = signed'(E_W'(gterm));
    gt_s  = signed'(U_W'(gterm));

    // Division of the error magnitude by 125 and of the integral magnitude
    // by 25, both by reciprocal multiplication.
    qe_prod = RQ_PW'(e_mag) * RQ_PW'(RQ_M);
    qa_prod = DP_W'(acc_mag) * DP_W'(DM);
    ra_c    = 5'(acc_mag - ACC_W'(qa_r) * ACC_W'(25));
    // floor(23*r/25) for a remainder r below 25 is r less ceil(2*r/25).
    if (ra_r == 5'd0) begin
      fr_c = 5'd0;
    end else if (ra_r <= 5'd12) begin
      fr_c = ra_r - 5'd1;
    end else begin
      fr_c = ra_r - 5'd2;
    end
    dec_mag = q23_r + ACC_W'(fr_c);

    // Integral update with the clamp at the integral limit.
    qe_s    = signed'(I_W'(qe_r));
    isum    = I_W'(acc_r) + (e_r[E_W-1] ? -qe_s : qe_s);
    lim_raw = {cfg.integral_limit, {(F - 8){1'b0}}};
    lim_u   = I_W'(lim_raw);
    if (lim_u > I_W'(INT32_MAX)) begin
      lim_u = I_W'(INT32_MAX);
    end
    lim_s = signed'(lim_u);
    if (isum > lim_s) begin
      inext_c = lim_s;
    end else if (isum < -lim_s) begin
      inext_c = -lim_s;
    end else begin
      inext_c = isum;
    end

    // Drive clamp.
    l_u  = {cfg.steer_limit, {F{1'b0}}};
    l_us = signed'(U_W'(l_u));
    if (usum_r > l_us) begin
      uc_c = UC_W'(l_us);
    end else if (usum_r < -l_us) begin
      uc_c = UC_W'(-l_us);
    end else begin
      uc_c = UC_W'(usum_r);
    end

    l_uc   = signed'(UC_W'(l_u));
    eps_c  = signed'(UC_W'(EPS));
    sat_hi = u_r >= l_uc - eps_c;
    sat_lo = u_r <= -l_uc + eps_c;
    hold   = (cfg.integ_gain != '0) &&
             ((sat_hi && inext_r > acc_r) || (sat_lo && inext_r < acc_r));
    u_mag  = u_r[UC_W-1] ? UC_W'(-u_r) : UC_W'(u_r);
    rnd    = u_mag + UC_W'(HALF);
    dmag_v = rnd[F+7:F];

    // Held drive while the line is lost.
    l_32 = signed'(ACC_W'(l_u));
    if (last_r > l_32) begin
      lc_c = l_32;
    end else if (last_r < -l_32) begin
      lc_c = -l_32;
    end else begin
      lc_c = last_r;
    end
    lc_mag   = lc_c[ACC_W-1] ? ACC_W'(-lc_c) : ACC_W'(lc_c);
    dmag_l   = lc_mag[F+7:F];
    loss_inc = (loss_r == '1) ? loss_r : loss_r + TICK_W'(1);

    // Shared multiplier operands.
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_PMUL: begin
        mul_a = cfg.predict_gain;
        mul_b = MUL_B'(sdiff_c);
      end
      OP_PROP_MUL: begin
        mul_a = cfg.prop_gain;
        mul_b = MUL_B'(e_mag);
      end
      OP_INT_MUL: begin
        mul_a = cfg.integ_gain;
        mul_b = MUL_B'(inext_mag);
      end
      default: mul_en = 1'b0;
    endcase

    // Shared divider operands, dividend left-aligned.
    div_start = 1'b1;
    div_num   = '0;
    div_nbits = '0;
    div_den   = '0;
    case (cmd.op)
      OP_NORM_DIV: begin
        div_num   = DIV_NW'({norm_d, {F{1'b0}}}) << (DIV_NW - (S + F));
        div_nbits = DCNT_W'(S + F);
        div_den   = DIV_DW'(maxv - minv);
      end
      OP_RATIO_DIV: begin
        div_num   = DIV_NW'({diff_c, {F{1'b0}}}) << (DIV_NW - (2 * F + 1));
        div_nbits = DCNT_W'(2 * F + 1);
        div_den   = DIV_DW'(sum_c);
      end
      default: div_start = 1'b0;
    endcase
  end

  // Loop state: integral, held drive, loss counter and decay flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      last_r  <= '0;
      loss_r  <= '0;
      decay_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          if (clear_i) begin
            acc_r  <= '0;
            last_r <= '0;
            loss_r <= '0;
          end
        end
        OP_COMMIT: begin
          if (!hold) begin
            acc_r <= inext_r;
          end
          last_r <= ACC_W'(u_r);
          loss_r <= '0;
        end
        OP_LOST: begin
          loss_r  <= loss_inc;
          decay_r <= loss_inc >= cfg.loss_timeout;
        end
        OP_DDIV_WB: begin
          acc_r <= acc_r[ACC_W-1] ? -signed'(dec_mag) : signed'(dec_mag);
        end
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    case (cmd.op)
      OP_LOAD: begin
        amp_r[0] <= lc_amp_i;
        amp_r[1] <= rc_amp_i;
        amp_r[2] <= lp_amp_i;
        amp_r[3] <= rp_amp_i;
      end
      OP_NORM_WB: begin
        nv_r[cmd.idx] <= cmd.idx[1] ? norm_v : three_half[N_W:1];
      end
      OP_RATIO_WB: begin
        ratio_r <= (nv_r[1] < nv_r[0]) ? -signed'(R_W'(norm_q)) : signed'(R_W'(norm_q));
      end
      OP_PMUL_WB: begin
        e_r <= E_W'(ratio_r) + ((nv_r[2] < nv_r[3]) ? -pt_s : pt_s);
      end
      OP_EDIV: qe_r <= QE_W'(qe_prod[RQ_PW-1:RQ_K]);
      OP_EDIV_WB: inext_r <= ACC_W'(inext_c);
      OP_PROP_WB: usum_r <= e_r[E_W-1] ? -gt_s : gt_s;
      OP_INT_WB: usum_r <= usum_r + (inext_r[ACC_W-1] ? -gt_s : gt_s);
      OP_CLAMP: u_r <= uc_c;
      OP_COMMIT: begin
        drive_r <= u_r[UC_W-1] ? -dmag_v : dmag_v;
        valid_r <= 1'b1;
      end
      OP_LOST: begin
        drive_r <= lc_c[ACC_W-1] ? -dmag_l : dmag_l;
        valid_r <= 1'b0;
      end
      OP_DMUL: qa_r <= qa_prod[DP_W-1:DK];
      OP_DDIV: begin
        ra_r  <= ra_c;
        q23_r <= ACC_W'(qa_r) * ACC_W'(23);
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.div_done  = div_done;
    stat.line_seen = sum_c > SUM_W'(VALID_MIN);
    stat.decay     = decay_r;
  end

  assign drive_o = drive_r;
  assign valid_o = valid_r;

endmodule
`default_nettype wire

[src/lfps_ctrl.sv]
`default_nettype none
// Sequencer: walks the datapath through one tick, at most one operation per state.
module lfps_ctrl import lfps_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  out_free,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       in_ready,
  output logic       publish
);

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE       = 5'd0;
  localparam logic [ST_W-1:0] ST_NORM       = 5'd1;
  localparam logic [ST_W-1:0] ST_NORM_WAIT  = 5'd2;
  localparam logic [ST_W-1:0] ST_CHECK      = 5'd3;
  localparam logic [ST_W-1:0] ST_RATIO_WAIT = 5'd4;
  localparam logic [ST_W-1:0] ST_PMUL       = 5'd5;
  localparam logic [ST_W-1:0] ST_PMUL_WB    = 5'd6;
  localparam logic [ST_W-1:0] ST_EDIV       = 5'd7;
  localparam logic [ST_W-1:0] ST_EDIV_WB    = 5'd8;
  localparam logic [ST_W-1:0] ST_PROP_MUL   = 5'd9;
  localparam logic [ST_W-1:0] ST_PROP_WB    = 5'd10;
  localparam logic [ST_W-1:0] ST_INT_MUL    = 5'd11;
  localparam logic [ST_W-1:0] ST_INT_WB     = 5'd12;
  localparam logic [ST_W-1:0] ST_CLAMP      = 5'd13;
  localparam logic [ST_W-1:0] ST_COMMIT     = 5'd14;
  localparam logic [ST_W-1:0] ST_LOST       = 5'd15;
  localparam logic [ST_W-1:0] ST_DDIV       = 5'd16;
  localparam logic [ST_W-1:0] ST_DDIV_WB    = 5'd17;
  localparam logic [ST_W-1:0] ST_DONE       = 5'd18;

  logic [ST_W-1:0] state_r, state_nxt;
  logic [1:0]      idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd.op    = OP_NONE;
    cmd.idx   = idx_r;
    in_ready  = 1'b0;
    publish   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        cmd.op    = OP_NORM_DIV;
        state_nxt = ST_NORM_WAIT;
      end
      ST_NORM_WAIT: begin
        if (stat.div_done) begin
          cmd.op    = OP_NORM_WB;
          idx_nxt   = idx_r + 2'd1;
          state_nxt = (idx_r == 2'd3) ? ST_CHECK : ST_NORM;
        end
      end
      ST_CHECK: begin
        if (stat.line_seen) begin
          cmd.op    = OP_RATIO_DIV;
          state_nxt = ST_RATIO_WAIT;
        end else begin
          cmd.op    = OP_LOST;
          state_nxt = ST_LOST;
        end
      end
      ST_RATIO_WAIT: begin
        if (stat.div_done) begin
          cmd.op    = OP_RATIO_WB;
          state_nxt = ST_PMUL;
        end
      end
      ST_PMUL: begin
        cmd.op    = OP_PMUL;
        state_nxt = ST_PMUL_WB;
      end
      ST_PMUL_WB: begin
        cmd.op    = OP_PMUL_WB;
        state_nxt = ST_EDIV;
      end
      ST_EDIV: begin
        cmd.op    = OP_EDIV;
        state_nxt = ST_EDIV_WB;
      end
      ST_EDIV_WB: begin
        cmd.op    = OP_EDIV_WB;
        state_nxt = ST_PROP_MUL;
      end
      ST_PROP_MUL: begin
        cmd.op    = OP_PROP_MUL;
        state_nxt = ST_PROP_WB;
      end
      ST_PROP_WB: begin
        cmd.op    = OP_PROP_WB;
        state_nxt = ST_INT_MUL;
      end
      ST_INT_MUL: begin
        cmd.op    = OP_INT_MUL;
        state_nxt = ST_INT_WB;
      end
      ST_INT_WB: begin
        cmd.op    = OP_INT_WB;
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.op    = OP_CLAMP;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.op    = OP_COMMIT;
        state_nxt = ST_DONE;
      end
      ST_LOST: begin
        if (stat.decay) begin
          cmd.op    = OP_DMUL;
          state_nxt = ST_DDIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DDIV: begin
        cmd.op    = OP_DDIV;
        state_nxt = ST_DDIV_WB;
      end
      ST_DDIV_WB: begin
        cmd.op    = OP_DDIV_WB;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          publish   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // An accepted transaction always starts the normalization walk.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_NORM && idx_r == 2'd0))
    else $error("accepted transaction did not start normalization");

  // The sensor index only moves while the four sensors are being normalized.
  a_idx_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_NORM && state_r != ST_NORM_WAIT) |-> (idx_r == 2'd0))
    else $error("sensor index left nonzero outside normalization");

  // The divider only finishes while the sequencer is waiting on it.
  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == ST_NORM_WAIT || state_r == ST_RATIO_WAIT))
    else $error("divider result arrived with nobody waiting");

  // A result is handed over exactly once per tick, then the block is idle.
  a_publish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    publish |=> (state_r == ST_IDLE))
    else $error("sequencer did not return to idle after a result");

endmodule
`default_nettype wire

[src/line_follow_pi_steering.sv]
`default_nettype none
// Channel  Dir  Handshake                    Payload
// in       in   in_tvalid / in_tready        tdata: four sensor amplitudes; tuser: clear
// out      out  out_tvalid / out_tready      tdata: steering drive; tuser: line seen
// cfg      in   cfg_psel / cfg_penable       APB register writes and reads
//
// A tick that sees the line runs the four normalizations, the position ratio
// and the control steps before it loads the output register; a tick with the
// line lost skips the ratio and the control steps and, when the integral
// decays, runs the decay steps. The shared one-bit-per-cycle divider serves
// the four normalizations and the position ratio in turn.
// Reset (synchronous, active low) clears the integral, the held drive, the
// loss counter and the registers to their documented defaults.
// One tick is worked on at a time; the next transaction is accepted as soon
// as the result has moved to the output register, even if the consumer stalls.
module line_follow_pi_steering import lfps_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int IN_W = ((4 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // left_center_amp, right_center_amp, left_predict_amp, right_predict_amp
  input  wire logic [IN_W-1:0]       in_tdata,
  // clear_state
  input  wire logic [0:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // steer_drive
  output logic [DRIVE_W-1:0]         out_tdata,
  // line_valid
  output logic [0:0]                 out_tuser,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  localparam int S = SAMPLE_BITS;

  // Configuration registers.
  logic [S-1:0]       min_count_r, max_count_r;
  logic [GAIN_W-1:0]  prop_gain_r, integ_gain_r, predict_gain_r, integral_limit_r;
  logic [LIMIT_W-1:0] steer_limit_r;
  logic [TICK_W-1:0]  loss_timeout_r;
  logic               cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  cfg_t               cfg;

  // Output register.
  logic               out_valid_r;
  logic [DRIVE_W-1:0] out_data_r;
  logic               out_user_r;

  cmd_t               cmd;
  stat_t              stat;
  logic               publish, out_free;
  logic [DRIVE_W-1:0] drive;
  logic               line_valid;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_count_r      <= S'(10);
      max_count_r      <= S'(100);
      prop_gain_r      <= GAIN_W'(4608);
      integ_gain_r     <= GAIN_W'(512);
      predict_gain_r   <= GAIN_W'(64);
      integral_limit_r <= GAIN_W'(7680);
      steer_limit_r    <= LIMIT_W'(11);
      loss_timeout_r   <= TICK_W'(32);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MIN_COUNT:      min_count_r      <= cfg_pwdata[S-1:0];
        REG_MAX_COUNT:      max_count_r      <= cfg_pwdata[S-1:0];
        REG_PROP_GAIN:      prop_gain_r      <= cfg_pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:     integ_gain_r     <= cfg_pwdata[GAIN_W-1:0];
        REG_PREDICT_GAIN:   predict_gain_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: integral_limit_r <= cfg_pwdata[GAIN_W-1:0];
        REG_STEER_LIMIT:    steer_limit_r    <= cfg_pwdata[LIMIT_W-1:0];
        REG_LOSS_TIMEOUT:   loss_timeout_r   <= cfg_pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      REG_MIN_COUNT:      cfg_prdata = CFG_DATA_W'(min_count_r);
      REG_MAX_COUNT:      cfg_prdata = CFG_DATA_W'(max_count_r);
      REG_PROP_GAIN:      cfg_prdata = CFG_DATA_W'(prop_gain_r);
      REG_INTEG_GAIN:     cfg_prdata = CFG_DATA_W'(integ_gain_r);
      REG_PREDICT_GAIN:   cfg_prdata = CFG_DATA_W'(predict_gain_r);
      REG_INTEGRAL_LIMIT: cfg_prdata = CFG_DATA_W'(integral_limit_r);
      REG_STEER_LIMIT:    cfg_prdata = CFG_DATA_W'(steer_limit_r);
      REG_LOSS_TIMEOUT:   cfg_prdata = CFG_DATA_W'(loss_timeout_r);
      default:            cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.min_count      = SAMPLE_MAX_W'(min_count_r);
    cfg.max_count      = SAMPLE_MAX_W'(max_count_r);
    cfg.prop_gain      = prop_gain_r;
    cfg.integ_gain     = integ_gain_r;
    cfg.predict_gain   = predict_gain_r;
    cfg.integral_limit = integral_limit_r;
    cfg.steer_limit    = steer_limit_r;
    cfg.loss_timeout   = loss_timeout_r;
  end

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_tready;

  lfps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_tready),
    .publish  (publish)
  );

  lfps_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .clear_i  (in_tuser[0]),
    .lc_amp_i (in_tdata[S-1:0]),
    .rc_amp_i (in_tdata[2*S-1:S]),
    .lp_amp_i (in_tdata[3*S-1:2*S]),
    .rp_amp_i (in_tdata[4*S-1:3*S]),
    .stat     (stat),
    .drive_o  (drive),
    .valid_o  (line_valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      out_data_r <= drive;
      out_user_r <= line_valid;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

endmodule
`default_nettype wire
